// ===== hw/rtl/bpfrc_pkg.sv =====
// package: request codes, entry layout and default sizes for the packet buffer
package bpfrc_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned LIMIT_W   = 7;
	localparam int unsigned LIMIT_RST = 64;
	localparam int unsigned COUNT_W   = 7;
	localparam int unsigned COUNT_MAX = 127;

	typedef enum logic [1:0] {
		REQ_ADD   = 2'd0,
		REQ_FWD   = 2'd1,
		REQ_COUNT = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef struct packed {
		logic [31:0] ts;
		logic [15:0] dst;
		logic [15:0] src;
	} entry_t;

endpackage

// ===== hw/rtl/bounded_packet_fifo_range_count_core.sv =====
// top level: bounded packet buffer with duplicate refusal and range count
//
// Usage:
//   s_* carries requests; s_tuser is the request kind (add, forward, count),
//   s_tdata the packet and the time window. m_* returns one result item per
//   request. cfg_* writes memory_limit, the most packets held; cfg_ready is
//   always high and writes belong in idle periods.
//   All packets sit in one entry memory with a single registered read port.
//   Add and count walk every stored entry at one entry per cycle; the result
//   item follows the last read. A forward reads only the oldest entry (none
//   when empty), an unknown kind none. Each request passes the idle, scan and
//   done steps, and the next request is accepted only once the last is back
//   in idle.
//   The result sits in an output register: the next request is accepted and
//   scanned while it waits, and the block holds in its final step only when
//   a second result is ready before the first is taken.
//   Reset empties the buffer (head and fill cleared, memory left as is) and
//   sets memory_limit to 64.
module bounded_packet_fifo_range_count_core
	import bpfrc_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// source[15:0], destination[31:16], timestamp[63:32], start_time[95:64],
	// end_time[127:96]
	input  logic [127:0]       s_tdata,
	// req_type[1:0]
	input  logic [1:0]         s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// ok[0], out_source[16:1], out_destination[32:17], out_timestamp[64:33],
	// match_count[71:65]
	output logic [71:0]        m_tdata,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LIMIT_W-1:0] cfg_data
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int unsigned SUM_W = CNT_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t               state_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic [IDX_W-1:0]     head_q;
	logic [CNT_W-1:0]     fill_q;

	req_t                 req_q;
	entry_t               key_q;
	logic [31:0]          lo_q;
	logic [31:0]          hi_q;

	logic [IDX_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     issued_q;
	logic [CNT_W-1:0]     len_q;
	logic                 vld_s1;
	entry_t               rd_data_s1;
	entry_t               last_q;
	logic                 dup_q;
	logic [CNT_W-1:0]     cnt_q;

	logic                 m_valid_q;
	logic [71:0]          m_data_q;

	entry_t               mem [DEPTH];
	logic                 mem_we;
	logic [IDX_W-1:0]     wr_addr;

	logic                 in_fire;
	logic                 done_fire;
	logic [CNT_W-1:0]     eff_lim;
	logic                 do_drop;
	logic [SUM_W-1:0]     tail_sum;
	logic [IDX_W-1:0]     head_next;
	logic [CNT_W-1:0]     scan_len;
	logic [COUNT_W-1:0]   count_sat;
	logic                 add_ok;
	logic                 fwd_ok;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
	endfunction

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid && s_tready;
	assign done_fire = (state_q == ST_DONE) && (!m_valid_q || m_tready);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;

	always_comb begin
		if (limit_q == '0) begin
			eff_lim = CNT_W'(1);
		end else if (LIM_W'(limit_q) > LIM_W'(DEPTH)) begin
			eff_lim = CNT_W'(DEPTH);
		end else begin
			eff_lim = CNT_W'(limit_q);
		end
	end

	assign do_drop   = (fill_q >= eff_lim);
	assign tail_sum  = SUM_W'(head_q) + SUM_W'(fill_q);
	assign wr_addr   = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
		: IDX_W'(tail_sum);
	assign head_next = idx_inc(head_q);
	assign add_ok    = (req_q == REQ_ADD) && !dup_q;
	assign fwd_ok    = (req_q == REQ_FWD) && (fill_q != '0);
	assign mem_we    = done_fire && add_ok;
	assign count_sat = (int'(cnt_q) > int'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
		: COUNT_W'(cnt_q);

	always_comb begin
		unique case (req_t'(s_tuser))
			REQ_ADD, REQ_COUNT: scan_len = fill_q;
			REQ_FWD:            scan_len = (fill_q != '0) ? CNT_W'(1) : '0;
			default:            scan_len = '0;
		endcase
	end

	// entry memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= key_q;
		end
		rd_data_s1 <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_W'(LIMIT_RST);
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q     <= req_t'(s_tuser);
			key_q.src <= s_tdata[15:0];
			key_q.dst <= s_tdata[31:16];
			key_q.ts  <= s_tdata[63:32];
			lo_q      <= s_tdata[95:64];
			hi_q      <= s_tdata[127:96];
			len_q     <= scan_len;
		end
		if (vld_s1) begin
			last_q <= rd_data_s1;
		end
		if (done_fire) begin
			m_data_q[0]     <= add_ok || fwd_ok;
			m_data_q[16:1]  <= fwd_ok ? last_q.src : '0;
			m_data_q[32:17] <= fwd_ok ? last_q.dst : '0;
			m_data_q[64:33] <= fwd_ok ? last_q.ts : '0;
			m_data_q[71:65] <= (req_q == REQ_COUNT) ? count_sat : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			fill_q    <= '0;
			rd_ptr_q  <= '0;
			issued_q  <= '0;
			vld_s1    <= 1'b0;
			dup_q     <= 1'b0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (done_fire) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (in_fire) begin
						rd_ptr_q <= head_q;
						issued_q <= '0;
						dup_q    <= 1'b0;
						cnt_q    <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issued_q != len_q) begin
						issued_q <= issued_q + CNT_W'(1);
						rd_ptr_q <= idx_inc(rd_ptr_q);
						vld_s1   <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							state_q <= ST_DONE;
						end
					end
					if (vld_s1) begin
						if (rd_data_s1 == key_q) begin
							dup_q <= 1'b1;
						end
						if (rd_data_s1.dst == key_q.dst && rd_data_s1.ts >= lo_q &&
							rd_data_s1.ts <= hi_q) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						if (add_ok) begin
							if (do_drop) begin
								head_q <= head_next;
							end else begin
								fill_q <= fill_q + CNT_W'(1);
							end
						end else if (fwd_ok) begin
							head_q <= head_next;
							fill_q <= fill_q - CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= int'(DEPTH))
		else $error("fill count above depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(head_q) < int'(DEPTH))
		else $error("head index out of range");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (issued_q <= len_q && len_q <= fill_q))
		else $error("scan ran past stored entries");

	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && m_valid_q && !m_tready) |=> (state_q == ST_DONE))
		else $error("result produced while output register busy");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result item without finished request");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for the bounded packet buffer: directed and random requests against a shadow buffer
module tb_top
	import bpfrc_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 1_500_000;

	typedef struct packed {
		logic [31:0] hi;
		logic [31:0] lo;
		logic [31:0] ts;
		logic [15:0] dst;
		logic [15:0] src;
	} request_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] src;
		logic [15:0] dst;
		logic [31:0] ts;
		logic [6:0]  cnt;
	} result_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [127:0]       s_tdata;
	logic [1:0]         s_tuser;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [71:0]        m_tdata;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data;

	entry_t             shadow_entry [DEPTH_DEF];
	int unsigned        shadow_head = 0;
	int unsigned        shadow_fill = 0;
	logic [LIMIT_W-1:0] shadow_limit = LIMIT_W'(LIMIT_RST);

	result_t     awaited_results [$];
	bit          idle_on = 1'b1;
	int unsigned sink_hold = 0;
	int unsigned sink_gap = 0;
	int unsigned cycle_count = 0;
	int unsigned n_errors = 0;
	int unsigned n_checked = 0;
	int unsigned n_refused = 0;
	int unsigned n_kind [4] = '{0, 0, 0, 0};

	bounded_packet_fifo_range_count_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("bounded_packet_fifo_range_count_core: mismatch");
			$finish;
		end
	end

	// receiver readiness: long hold, random bursts, or ready
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 6) == 0) begin
			sink_gap = $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		if (n_errors <= 50)
			$display("error at result %0d: %s got %0h want %0h", n_checked, what, got, want);
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.ok  = m_tdata[0];
			got.src = m_tdata[16:1];
			got.dst = m_tdata[32:17];
			got.ts  = m_tdata[64:33];
			got.cnt = m_tdata[71:65];
			if (awaited_results.size() == 0) begin
				report_mismatch("result with nothing awaited", m_tdata[31:0], 32'd0);
			end else begin
				want = awaited_results.pop_front();
				if (got.ok !== want.ok)
					report_mismatch("ok", 32'(got.ok), 32'(want.ok));
				if (got.src !== want.src)
					report_mismatch("out_source", 32'(got.src), 32'(want.src));
				if (got.dst !== want.dst)
					report_mismatch("out_destination", 32'(got.dst), 32'(want.dst));
				if (got.ts !== want.ts)
					report_mismatch("out_timestamp", got.ts, want.ts);
				if (got.cnt !== want.cnt)
					report_mismatch("match_count", 32'(got.cnt), 32'(want.cnt));
			end
			n_checked++;
		end
	end

	// shadow buffer: one request in, one result out
	task automatic buffer_step(input req_t kind, input request_t req, output result_t r);
		int unsigned lim;
		int unsigned n;
		int unsigned slot;
		bit          dup;
		r = '0;
		n = 0;
		dup = 1'b0;
		lim = 32'(shadow_limit);
		if (lim < 1)
			lim = 1;
		if (lim > DEPTH_DEF)
			lim = DEPTH_DEF;
		case (kind)
			REQ_ADD: begin
				for (int unsigned i = 0; i < shadow_fill; i++) begin
					slot = (shadow_head + i) % DEPTH_DEF;
					if (shadow_entry[slot].src == req.src && shadow_entry[slot].dst == req.dst &&
							shadow_entry[slot].ts == req.ts)
						dup = 1'b1;
				end
				if (!dup) begin
					if (shadow_fill >= lim && shadow_fill > 0) begin
						shadow_head = (shadow_head + 1) % DEPTH_DEF;
						shadow_fill--;
					end
					slot = (shadow_head + shadow_fill) % DEPTH_DEF;
					shadow_entry[slot].src = req.src;
					shadow_entry[slot].dst = req.dst;
					shadow_entry[slot].ts  = req.ts;
					shadow_fill++;
					r.ok = 1'b1;
				end
			end
			REQ_FWD: begin
				if (shadow_fill > 0) begin
					r.ok  = 1'b1;
					r.src = shadow_entry[shadow_head].src;
					r.dst = shadow_entry[shadow_head].dst;
					r.ts  = shadow_entry[shadow_head].ts;
					shadow_head = (shadow_head + 1) % DEPTH_DEF;
					shadow_fill--;
				end
			end
			REQ_COUNT: begin
				for (int unsigned i = 0; i < shadow_fill; i++) begin
					slot = (shadow_head + i) % DEPTH_DEF;
					if (shadow_entry[slot].dst == req.dst && shadow_entry[slot].ts >= req.lo &&
							shadow_entry[slot].ts <= req.hi)
						n++;
				end
				if (n > COUNT_MAX)
					n = COUNT_MAX;
				r.cnt = COUNT_W'(n);
			end
			default: begin
			end
		endcase
	endtask

	function automatic request_t req_of(input logic [15:0] src, input logic [15:0] dst,
			input logic [31:0] ts, input logic [31:0] lo, input logic [31:0] hi);
		request_t req;
		req.src = src;
		req.dst = dst;
		req.ts  = ts;
		req.lo  = lo;
		req.hi  = hi;
		return req;
	endfunction

	task automatic send_request(input req_t kind, input request_t req);
		result_t r;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= req;
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		buffer_step(kind, req, r);
		awaited_results.push_back(r);
		n_kind[kind]++;
		if (kind == REQ_ADD && !r.ok)
			n_refused++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		shadow_limit = value;
		@(posedge clk);
	endtask

	task automatic set_idling(input bit on);
		@(negedge clk);
		idle_on = on;
		@(posedge clk);
	endtask

	function automatic req_t pick_kind();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 52)
			return REQ_ADD;
		else if (roll < 72)
			return REQ_FWD;
		else if (roll < 95)
			return REQ_COUNT;
		return REQ_NONE;
	endfunction

	// mostly a small pool of packets so that duplicates and matches are common
	function automatic request_t make_payload(input req_t kind);
		request_t req;
		req.src = 16'($urandom);
		req.dst = 16'($urandom);
		req.ts  = $urandom;
		req.lo  = $urandom;
		req.hi  = $urandom;
		if ($urandom_range(0, 2) != 0) begin
			req.src = 16'hA000 | 16'($urandom_range(0, 3));
			req.dst = 16'h5A00 | 16'($urandom_range(0, 3));
			req.ts  = $urandom_range(0, 15);
			if (kind == REQ_COUNT) begin
				case ($urandom_range(0, 3))
					0: begin
						req.lo = 32'd0;
						req.hi = 32'hFFFF_FFFF;
					end
					1: begin
						req.lo = $urandom_range(0, 15);
						req.hi = req.lo + $urandom_range(0, 15);
					end
					2: begin
						req.lo = $urandom_range(1, 15);
						req.hi = req.lo - $urandom_range(1, req.lo);
					end
					default: begin
					end
				endcase
			end
		end
		return req;
	endfunction

	task automatic test_empty_and_unknown();
		send_request(REQ_FWD, req_of(16'h1111, 16'h2222, 32'h3333, 32'h0, 32'h0));
		send_request(REQ_COUNT, req_of(16'h0, 16'h0, 32'h0, 32'h0, 32'hFFFF_FFFF));
		send_request(REQ_NONE, req_of(16'hFFFF, 16'hFFFF, '1, '1, '1));
	endtask

	task automatic test_add_count_forward();
		send_request(REQ_ADD, req_of(16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0));
		send_request(REQ_ADD, req_of(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, '1, '1));
		send_request(REQ_ADD, req_of(16'h0000, 16'h0000, 32'h0, '1, '1));
		send_request(REQ_ADD, req_of(16'h0001, 16'hFFFF, 32'h5, 32'h0, 32'h0));
		send_request(REQ_COUNT, req_of(16'h0, 16'hFFFF, 32'h0, 32'h0, 32'hFFFF_FFFF));
		send_request(REQ_COUNT, req_of(16'h0, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'h0));
		send_request(REQ_COUNT, req_of(16'h0, 16'hFFFF, 32'h0, 32'h5, 32'h5));
		send_request(REQ_COUNT, req_of(16'h0, 16'h0000, 32'h0, 32'h0, 32'h0));
		send_request(REQ_FWD, req_of(16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
		send_request(REQ_FWD, req_of(16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
		send_request(REQ_FWD, req_of(16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
		send_request(REQ_FWD, req_of(16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
	endtask

	task automatic test_limit_drop_oldest();
		write_limit(7'd2);
		send_request(REQ_ADD, req_of(16'h0010, 16'h0020, 32'h100, 32'h0, 32'h0));
		send_request(REQ_ADD, req_of(16'h0011, 16'h0020, 32'h101, 32'h0, 32'h0));
		send_request(REQ_ADD, req_of(16'h0012, 16'h0020, 32'h102, 32'h0, 32'h0));
		send_request(REQ_FWD, req_of(16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
	endtask

	task automatic test_limit_clamp();
		write_limit(7'd0);
		send_request(REQ_ADD, req_of(16'h0030, 16'h0040, 32'h200, 32'h0, 32'h0));
		send_request(REQ_ADD, req_of(16'h0031, 16'h0040, 32'h201, 32'h0, 32'h0));
		send_request(REQ_COUNT, req_of(16'h0, 16'h0040, 32'h0, 32'h0, 32'hFFFF_FFFF));
	endtask

	task automatic test_limit_lowered();
		write_limit(7'd64);
		for (int i = 0; i < 3; i++)
			send_request(REQ_ADD, req_of(16'h0050 + 16'(i), 16'h0040, 32'h300 + 32'(i),
				32'h0, 32'h0));
		write_limit(7'd2);
		send_request(REQ_ADD, req_of(16'h0060, 16'h0040, 32'h400, 32'h0, 32'h0));
		send_request(REQ_COUNT, req_of(16'h0, 16'h0040, 32'h0, 32'h0, 32'hFFFF_FFFF));
	endtask

	task automatic test_random_traffic(input int n_items, input logic [LIMIT_W-1:0] lim,
			input bit idling);
		req_t kind;
		write_limit(lim);
		set_idling(idling);
		for (int i = 0; i < n_items; i++) begin
			kind = pick_kind();
			send_request(kind, make_payload(kind));
		end
	endtask

	// receiver holds off while requests keep coming, so the input stalls
	task automatic test_output_stall();
		req_t kind;
		write_limit(7'd16);
		set_idling(1'b0);
		@(negedge clk);
		sink_hold = 400;
		@(posedge clk);
		for (int i = 0; i < 24; i++) begin
			kind = ($urandom_range(0, 2) == 0) ? REQ_COUNT : REQ_ADD;
			send_request(kind, make_payload(kind));
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= REQ_ADD;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_unknown();
		test_add_count_forward();
		test_limit_drop_oldest();
		test_limit_clamp();
		test_limit_lowered();
		test_random_traffic(200, 7'd127, 1'b1);
		test_random_traffic(150, 7'd1, 1'b1);
		test_random_traffic(300, 7'd64, 1'b1);
		test_random_traffic(150, LIMIT_W'($urandom_range(3, 63)), 1'b1);
		test_random_traffic(100, 7'd0, 1'b1);
		test_random_traffic(100, 7'd2, 1'b1);
		test_output_stall();
		test_random_traffic(300, 7'd40, 1'b0);

		wait_idle();
		repeat (20) @(posedge clk);
		$display("requests sent: %0d add (%0d refused as duplicate), %0d forward, %0d count, %0d unknown",
			n_kind[REQ_ADD], n_refused, n_kind[REQ_FWD], n_kind[REQ_COUNT], n_kind[REQ_NONE]);
		$display("%0d results checked over limits 0 to 127, random idling, a long output stall",
			n_checked);
		if (n_errors == 0)
			$display("bounded_packet_fifo_range_count_core: match");
		else
			$display("bounded_packet_fifo_range_count_core: mismatch");
		$finish;
	end

endmodule
